// ----- rtl/raster_primitive_walker_macros.svh -----
// Assertion macros for the raster primitive walker.
// Included by the top level; no other dependencies.
`ifndef RASTER_PRIMITIVE_WALKER_MACROS_SVH
`define RASTER_PRIMITIVE_WALKER_MACROS_SVH

// Same-cycle implication, checked only out of reset
`define RPW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rpw: implication check failed");

// Next-cycle implication, checked only out of reset
`define RPW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rpw: next-cycle check failed");

`endif

// ----- rtl/rpw_pkg.sv -----
// Shared types and fixed constants of the raster primitive walker.
// No dependencies; imported by rpw_clip_addr, raster_primitive_walker and tb_top.
package rpw_pkg;

    localparam int CFG_W      = 13;
    localparam int ADDR_W     = 24;
    localparam int COLOR_W    = 32;
    localparam int PSIZE_W    = 8;
    localparam int MODE_W     = 2;

    localparam logic [CFG_W-1:0] FRAME_W_RESET = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_H_RESET = 13'd480;

    // Request opcodes
    typedef enum logic [MODE_W-1:0] {
        MODE_STEP  = 2'd0,
        MODE_LINE  = 2'd1,
        MODE_RECT  = 2'd2,
        MODE_POINT = 2'd3
    } t_mode;

    // Configuration register indexes
    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    // Clip result handed from the clip/address unit to the top level
    typedef struct packed {
        logic              in_frame;
        logic [ADDR_W-1:0] addr;
    } t_clip_res;

endpackage

// ----- rtl/rpw_clip_addr.sv -----
// Clip test and linear address for one pixel of the raster primitive walker.
// Depends on rpw_pkg (t_clip_res, ADDR_W).
module rpw_clip_addr
    import rpw_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAME_BITS = 13
) (
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  logic        [FRAME_BITS-1:0] i_width,
    input  logic        [FRAME_BITS-1:0] i_height,
    output t_clip_res                    o_res
);

    localparam int CW   = ((COORD_BITS > FRAME_BITS) ? COORD_BITS : FRAME_BITS) + 1;
    localparam int PW   = 2 * FRAME_BITS + 1;

    logic [CW-1:0]          w_xu;
    logic [CW-1:0]          w_yu;
    logic [CW-1:0]          w_wu;
    logic [CW-1:0]          w_hu;
    logic                   w_inside;
    logic [PW-1:0]          w_sum;
    logic [PW+ADDR_W-1:0]   w_sum_ext;

    // Zero-extend everything to a common compare width
    assign w_xu = {{(CW-COORD_BITS){1'b0}}, i_x};
    assign w_yu = {{(CW-COORD_BITS){1'b0}}, i_y};
    assign w_wu = {{(CW-FRAME_BITS){1'b0}}, i_width};
    assign w_hu = {{(CW-FRAME_BITS){1'b0}}, i_height};

    // Inside when both coordinates are non-negative and below the frame size
    assign w_inside = !i_x[COORD_BITS-1] && !i_y[COORD_BITS-1] &&
                      (w_xu < w_wu) && (w_yu < w_hu);

    // y * width + x; operands fit FRAME_BITS whenever the pixel is inside
    assign w_sum = PW'(w_yu[FRAME_BITS-1:0] * i_width) +
                   PW'(w_xu[FRAME_BITS-1:0]);
    assign w_sum_ext = {{ADDR_W{1'b0}}, w_sum};

    assign o_res.in_frame = w_inside;
    assign o_res.addr     = w_inside ? w_sum_ext[ADDR_W-1:0] : '0;

endmodule

// ----- rtl/raster_primitive_walker.sv -----
// Raster primitive walker top level: command decode, walker state, output register.
// Depends on rpw_pkg, rpw_clip_addr and raster_primitive_walker_macros.svh.
//
//  channel | handshake                  | moves
//  --------+----------------------------+-------------------------------------------
//  in      | i_in_valid / o_in_ready    | mode, start/end corners, point size, color
//  out     | o_out_valid / i_out_ready  | pixel x/y, address, color, we, last flag
//  cfg     | i_cfg_we (no wait)         | frame_width / frame_height
//
// One request per cycle; a step request yields its pixel in the cycle after acceptance
// from the output register. The pixel path is the clip compare plus one
// FRAME_BITS x FRAME_BITS multiply and add, feeding the output register directly.
// o_in_ready is low only while the output register holds a pixel that is not taken.
// Reset (synchronous, active low) idles the walker, empties the output register and
// loads a 640 x 480 frame.
`include "raster_primitive_walker_macros.svh"

module raster_primitive_walker
    import rpw_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int MAX_FRAME  = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [MODE_W-1:0]             i_mode,
    input  logic signed [COORD_BITS-1:0]  i_start_x,
    input  logic signed [COORD_BITS-1:0]  i_start_y,
    input  logic signed [COORD_BITS-1:0]  i_end_x,
    input  logic signed [COORD_BITS-1:0]  i_end_y,
    input  logic [PSIZE_W-1:0]            i_point_size,
    input  logic [COLOR_W-1:0]            i_draw_color,
    // pixel channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_BITS-1:0]  o_pixel_x,
    output logic signed [COORD_BITS-1:0]  o_pixel_y,
    output logic [ADDR_W-1:0]             o_pixel_address,
    output logic [COLOR_W-1:0]            o_pixel_color,
    output logic                          o_write_enable,
    output logic                          o_last_pixel
);

    localparam int C      = COORD_BITS;
    localparam int DX_W   = C + 2;
    localparam int ERR_W  = C + 3;
    localparam int E2_W   = C + 4;
    localparam int EXT_W  = C + 2;
    localparam int FW     = $clog2(MAX_FRAME + 1);
    localparam logic [C-1:0] ONE = {{(C-1){1'b0}}, 1'b1};

    // Clamp an extended coordinate into the signed coordinate range
    function automatic logic [C-1:0] sat_coord(input logic [EXT_W-1:0] v);
        logic [C-1:0] res;
        if (v[EXT_W-1:C-1] == '0 || v[EXT_W-1:C-1] == '1) begin
            res = v[C-1:0];
        end else if (v[EXT_W-1]) begin
            res = {1'b1, {(C-1){1'b0}}};
        end else begin
            res = {1'b0, {(C-1){1'b1}}};
        end
        return res;
    endfunction

    // Configuration registers
    logic [CFG_W-1:0] r_frame_w;
    logic [CFG_W-1:0] r_frame_h;

    // Walker state
    logic                    r_active,  n_active;
    logic                    r_line,    n_line;
    logic signed [C-1:0]     r_cur_x,   n_cur_x;
    logic signed [C-1:0]     r_cur_y,   n_cur_y;
    logic signed [C-1:0]     r_tgt_x,   n_tgt_x;
    logic signed [C-1:0]     r_tgt_y,   n_tgt_y;
    logic signed [C-1:0]     r_left_x,  n_left_x;
    logic                    r_dir_x,   n_dir_x;
    logic                    r_dir_y,   n_dir_y;
    logic signed [DX_W-1:0]  r_dx,      n_dx;
    logic signed [DX_W-1:0]  r_ndy,     n_ndy;
    logic signed [ERR_W-1:0] r_err,     n_err;
    logic [COLOR_W-1:0]      r_color,   n_color;

    // Output register
    logic                    r_out_valid;
    logic signed [C-1:0]     r_px;
    logic signed [C-1:0]     r_py;
    logic [ADDR_W-1:0]       r_paddr;
    logic [COLOR_W-1:0]      r_pcolor;
    logic                    r_pwe;
    logic                    r_plast;

    logic                    w_in_fire;
    logic                    w_produce;
    logic                    w_last;
    logic [FW-1:0]           w_eff_w;
    logic [FW-1:0]           w_eff_h;
    t_clip_res               w_clip;

    // Line setup
    logic signed [C:0]       w_ddx;
    logic signed [C:0]       w_ddy;
    logic signed [DX_W-1:0]  w_ddx_e;
    logic signed [DX_W-1:0]  w_ddy_e;
    logic signed [DX_W-1:0]  w_dx_ld;
    logic signed [DX_W-1:0]  w_ndy_ld;

    // Fill setup
    logic [EXT_W-1:0]        w_half;
    logic [EXT_W-1:0]        w_size;
    logic [EXT_W-1:0]        w_x0e;
    logic [EXT_W-1:0]        w_y0e;
    logic signed [C-1:0]     w_fax, w_fay, w_fbx, w_fby;
    logic signed [C-1:0]     w_lo_x, w_hi_x, w_lo_y, w_hi_y;

    // Line step
    logic signed [E2_W-1:0]  w_e2;
    logic                    w_mv_x;
    logic                    w_mv_y;

    assign w_in_fire  = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_produce  = w_in_fire && (i_mode == MODE_STEP) && r_active;
    assign w_last     = (r_cur_x == r_tgt_x) && (r_cur_y == r_tgt_y);

    // Effective frame size, capped at MAX_FRAME
    assign w_eff_w = (32'(r_frame_w) > 32'(MAX_FRAME)) ? FW'(MAX_FRAME) : FW'(r_frame_w);
    assign w_eff_h = (32'(r_frame_h) > 32'(MAX_FRAME)) ? FW'(MAX_FRAME) : FW'(r_frame_h);

    rpw_clip_addr #(
        .COORD_BITS (C),
        .FRAME_BITS (FW)
    ) u_clip (
        .i_x      (r_cur_x),
        .i_y      (r_cur_y),
        .i_width  (w_eff_w),
        .i_height (w_eff_h),
        .o_res    (w_clip)
    );

    // Line deltas
    assign w_ddx    = {i_end_x[C-1], i_end_x} - {i_start_x[C-1], i_start_x};
    assign w_ddy    = {i_end_y[C-1], i_end_y} - {i_start_y[C-1], i_start_y};
    assign w_ddx_e  = {w_ddx[C], w_ddx};
    assign w_ddy_e  = {w_ddy[C], w_ddy};
    assign w_dx_ld  = w_ddx_e[DX_W-1] ? -w_ddx_e : w_ddx_e;
    assign w_ndy_ld = w_ddy_e[DX_W-1] ? w_ddy_e : -w_ddy_e;

    // Fill corners; for a point, saturated to the coordinate range
    assign w_half = {{(EXT_W-PSIZE_W+1){1'b0}}, i_point_size[PSIZE_W-1:1]};
    assign w_size = {{(EXT_W-PSIZE_W){1'b0}}, i_point_size};
    assign w_x0e  = {{2{i_start_x[C-1]}}, i_start_x};
    assign w_y0e  = {{2{i_start_y[C-1]}}, i_start_y};

    always_comb begin
        if (i_mode == MODE_POINT) begin
            w_fax = sat_coord(w_x0e - w_half);
            w_fay = sat_coord(w_y0e - w_half);
            w_fbx = sat_coord(w_x0e + w_size - w_half - EXT_W'(1));
            w_fby = sat_coord(w_y0e + w_size - w_half - EXT_W'(1));
        end else begin
            w_fax = i_start_x;
            w_fay = i_start_y;
            w_fbx = i_end_x;
            w_fby = i_end_y;
        end
    end

    // Corner sort
    assign w_lo_x = (w_fax > w_fbx) ? w_fbx : w_fax;
    assign w_hi_x = (w_fax > w_fbx) ? w_fax : w_fbx;
    assign w_lo_y = (w_fay > w_fby) ? w_fby : w_fay;
    assign w_hi_y = (w_fay > w_fby) ? w_fay : w_fby;

    // Bresenham decision
    assign w_e2   = {r_err[ERR_W-1], r_err} <<< 1;
    assign w_mv_x = w_e2 >= E2_W'(r_ndy);
    assign w_mv_y = w_e2 <= E2_W'(r_dx);

    // Next walker state
    always_comb begin
        n_active = r_active;
        n_line   = r_line;
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_tgt_x  = r_tgt_x;
        n_tgt_y  = r_tgt_y;
        n_left_x = r_left_x;
        n_dir_x  = r_dir_x;
        n_dir_y  = r_dir_y;
        n_dx     = r_dx;
        n_ndy    = r_ndy;
        n_err    = r_err;
        n_color  = r_color;
        if (w_in_fire) begin
            case (t_mode'(i_mode))
                MODE_STEP: begin
                    if (r_active) begin
                        if (w_last) begin
                            n_active = 1'b0;
                        end else if (r_line) begin
                            n_err = r_err + (w_mv_x ? ERR_W'(r_ndy) : '0)
                                          + (w_mv_y ? ERR_W'(r_dx) : '0);
                            if (w_mv_x) begin
                                n_cur_x = r_dir_x ? r_cur_x - ONE : r_cur_x + ONE;
                            end
                            if (w_mv_y) begin
                                n_cur_y = r_dir_y ? r_cur_y - ONE : r_cur_y + ONE;
                            end
                        end else if (r_cur_x == r_tgt_x) begin
                            n_cur_x = r_left_x;
                            n_cur_y = r_cur_y + ONE;
                        end else begin
                            n_cur_x = r_cur_x + ONE;
                        end
                    end
                end
                MODE_LINE: begin
                    n_color  = i_draw_color;
                    n_cur_x  = i_start_x;
                    n_cur_y  = i_start_y;
                    n_tgt_x  = i_end_x;
                    n_tgt_y  = i_end_y;
                    n_dx     = w_dx_ld;
                    n_ndy    = w_ndy_ld;
                    n_dir_x  = !(i_start_x < i_end_x);
                    n_dir_y  = !(i_start_y < i_end_y);
                    n_err    = ERR_W'(w_dx_ld) + ERR_W'(w_ndy_ld);
                    n_line   = 1'b1;
                    n_active = 1'b1;
                end
                MODE_RECT, MODE_POINT: begin
                    n_color = i_draw_color;
                    if (i_mode == MODE_POINT && i_point_size == '0) begin
                        // empty point: nothing to draw
                        n_active = 1'b0;
                        n_line   = 1'b0;
                    end else begin
                        n_cur_x  = w_lo_x;
                        n_cur_y  = w_lo_y;
                        n_left_x = w_lo_x;
                        n_tgt_x  = w_hi_x;
                        n_tgt_y  = w_hi_y;
                        n_line   = 1'b0;
                        n_active = 1'b1;
                    end
                end
                default: begin
                    n_active = r_active;
                end
            endcase
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= FRAME_W_RESET;
            r_frame_h <= FRAME_H_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_frame_w <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_h <= i_cfg_data;
                default: r_frame_w <= r_frame_w;
            endcase
        end
    end

    // Walker control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_line   <= 1'b0;
        end else begin
            r_active <= n_active;
            r_line   <= n_line;
        end
    end

    // Walker datapath state
    always_ff @(posedge i_clk) begin
        r_cur_x  <= n_cur_x;
        r_cur_y  <= n_cur_y;
        r_tgt_x  <= n_tgt_x;
        r_tgt_y  <= n_tgt_y;
        r_left_x <= n_left_x;
        r_dir_x  <= n_dir_x;
        r_dir_y  <= n_dir_y;
        r_dx     <= n_dx;
        r_ndy    <= n_ndy;
        r_err    <= n_err;
        r_color  <= n_color;
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_produce) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_produce) begin
            r_px     <= r_cur_x;
            r_py     <= r_cur_y;
            r_paddr  <= w_clip.addr;
            r_pcolor <= r_color;
            r_pwe    <= w_clip.in_frame;
            r_plast  <= w_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_x       = r_px;
    assign o_pixel_y       = r_py;
    assign o_pixel_address = r_paddr;
    assign o_pixel_color   = r_pcolor;
    assign o_write_enable  = r_pwe;
    assign o_last_pixel    = r_plast;

    // Checks
    `RPW_ASSERT_IMPL(a_out_from_step, i_clk, i_rst_n, $rose(r_out_valid), $past(w_produce))
    `RPW_ASSERT_IMPL(a_clipped_addr_zero, i_clk, i_rst_n, r_out_valid && !r_pwe, r_paddr == '0)
    `RPW_ASSERT_NEXT(a_last_idles, i_clk, i_rst_n, w_produce && w_last, !r_active)
    `RPW_ASSERT_IMPL(a_fill_in_box, i_clk, i_rst_n, r_active && !r_line,
        (r_cur_y <= r_tgt_y) && (r_cur_x <= r_tgt_x) && (r_cur_x >= r_left_x))

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for raster_primitive_walker: scoreboard class with a
// behavioral pixel predictor, request/pixel handshake drivers and frame-size phases.
// Depends on rpw_pkg and the raster_primitive_walker RTL only.
module tb_top;
    import rpw_pkg::*;

    localparam int FRAME_CAP = 4096;
    localparam int ITEM_GOAL = 1550;
    localparam int RUN_LIMIT = 800000;
    localparam int NUM_PHASES = 7;

    typedef struct {
        t_mode                mode;
        logic signed [15:0]   sx, sy, ex, ey;
        logic [PSIZE_W-1:0]   psize;
        logic [COLOR_W-1:0]   color;
    } t_draw_req;

    typedef struct {
        logic signed [15:0]   x, y;
        logic [ADDR_W-1:0]    addr;
        logic [COLOR_W-1:0]   color;
        logic                 we, last;
    } t_pixel;

    // Predicts the pixel stream and checks the block's output against it
    class pixel_scoreboard;
        t_pixel               expected_pixels[$];
        logic [CFG_W-1:0]     frame_w, frame_h;
        bit                   active, on_line, neg_x, neg_y;
        logic signed [15:0]   cur_x, cur_y, tgt_x, tgt_y, row_left;
        int                   dx_abs, dy_neg, err;
        logic [COLOR_W-1:0]   color;
        int                   mismatches, checked, clipped;

        function new();
            frame_w = FRAME_W_RESET;
            frame_h = FRAME_H_RESET;
            active = 0;
            on_line = 0;
            mismatches = 0;
            checked = 0;
            clipped = 0;
        endfunction

        function void set_frame(t_cfg_idx idx, logic [CFG_W-1:0] v);
            if (idx == CFG_FRAME_WIDTH) frame_w = v;
            else frame_h = v;
        endfunction

        function int clamp16(int v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        // Rectangle walk with sorted corners
        function void load_fill(int xa, int ya, int xb, int yb);
            int t;
            if (xa > xb) begin t = xa; xa = xb; xb = t; end
            if (ya > yb) begin t = ya; ya = yb; yb = t; end
            cur_x = xa[15:0];
            cur_y = ya[15:0];
            row_left = xa[15:0];
            tgt_x = xb[15:0];
            tgt_y = yb[15:0];
            on_line = 0;
            active = 1;
        endfunction

        function void note_request(t_draw_req r);
            int     w, h, e2, half, sz;
            bit     in_frame;
            t_pixel px;
            // commands load a new primitive and never emit a pixel
            if (r.mode != MODE_STEP) begin
                color = r.color;
                case (r.mode)
                    MODE_LINE: begin
                        cur_x = r.sx;
                        cur_y = r.sy;
                        tgt_x = r.ex;
                        tgt_y = r.ey;
                        dx_abs = (r.ex > r.sx) ? int'(r.ex) - int'(r.sx)
                                               : int'(r.sx) - int'(r.ex);
                        dy_neg = (r.ey > r.sy) ? int'(r.sy) - int'(r.ey)
                                               : int'(r.ey) - int'(r.sy);
                        neg_x = !(r.sx < r.ex);
                        neg_y = !(r.sy < r.ey);
                        err = dx_abs + dy_neg;
                        on_line = 1;
                        active = 1;
                    end
                    MODE_RECT: load_fill(r.sx, r.sy, r.ex, r.ey);
                    default: begin
                        sz = r.psize;
                        half = sz / 2;
                        if (sz == 0) begin
                            active = 0;
                            on_line = 0;
                        end else begin
                            load_fill(clamp16(r.sx - half), clamp16(r.sy - half),
                                      clamp16(r.sx + sz - half - 1),
                                      clamp16(r.sy + sz - half - 1));
                        end
                    end
                endcase
                return;
            end
            if (!active) return;

            // emit the cursor pixel, clipped against the capped frame
            w = (frame_w > FRAME_CAP) ? FRAME_CAP : int'(frame_w);
            h = (frame_h > FRAME_CAP) ? FRAME_CAP : int'(frame_h);
            in_frame = cur_x >= 0 && cur_y >= 0 && int'(cur_x) < w && int'(cur_y) < h;
            px.x = cur_x;
            px.y = cur_y;
            px.we = in_frame;
            px.addr = in_frame ? 24'(int'(cur_y) * w + int'(cur_x)) : '0;
            px.color = color;
            px.last = (cur_x == tgt_x && cur_y == tgt_y);
            expected_pixels.push_back(px);

            // advance the walk
            if (px.last) begin
                active = 0;
            end else if (on_line) begin
                e2 = 2 * err;
                if (e2 >= dy_neg) begin
                    err += dy_neg;
                    cur_x = neg_x ? cur_x - 16'sd1 : cur_x + 16'sd1;
                end
                if (e2 <= dx_abs) begin
                    err += dx_abs;
                    cur_y = neg_y ? cur_y - 16'sd1 : cur_y + 16'sd1;
                end
            end else if (cur_x == tgt_x) begin
                cur_x = row_left;
                cur_y = cur_y + 16'sd1;
            end else begin
                cur_x = cur_x + 16'sd1;
            end
        endfunction

        function void flag(string what, t_pixel want, t_pixel got);
            mismatches++;
            if (mismatches <= 10)
                $display({"MISMATCH %s: exp x=%0d y=%0d addr=%h col=%h we=%b last=%b",
                          " | got x=%0d y=%0d addr=%h col=%h we=%b last=%b"},
                         what, want.x, want.y, want.addr, want.color, want.we, want.last,
                         got.x, got.y, got.addr, got.color, got.we, got.last);
        endfunction

        function void check_pixel(t_pixel got);
            t_pixel want;
            if (expected_pixels.size() == 0) begin
                want = got;
                flag("unexpected pixel", want, got);
                return;
            end
            want = expected_pixels.pop_front();
            checked++;
            if (!want.we) clipped++;
            if (got.x !== want.x || got.y !== want.y || got.addr !== want.addr ||
                got.color !== want.color || got.we !== want.we || got.last !== want.last)
                flag("pixel fields", want, got);
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic                   i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [MODE_W-1:0]      i_mode;
    logic signed [15:0]     i_start_x, i_start_y, i_end_x, i_end_y;
    logic [PSIZE_W-1:0]     i_point_size;
    logic [COLOR_W-1:0]     i_draw_color;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic signed [15:0]     o_pixel_x, o_pixel_y;
    logic [ADDR_W-1:0]      o_pixel_address;
    logic [COLOR_W-1:0]     o_pixel_color;
    logic                   o_write_enable;
    logic                   o_last_pixel;

    pixel_scoreboard sb;
    bit              steady;
    int              sent;
    int              settings_used;

    raster_primitive_walker uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_point_size    (i_point_size),
        .i_draw_color    (i_draw_color),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_write_enable  (o_write_enable),
        .o_last_pixel    (o_last_pixel)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones, none in steady stretches
    function automatic int idle_len();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic t_draw_req make_req(t_mode m, int sx, int sy, int ex, int ey,
                                           int psize, logic [31:0] color);
        t_draw_req r;
        r.mode = m;
        r.sx = sx[15:0];
        r.sy = sy[15:0];
        r.ex = ex[15:0];
        r.ey = ey[15:0];
        r.psize = psize[7:0];
        r.color = color;
        return r;
    endfunction

    // Step request; the other fields are don't-care and get random values
    function automatic t_draw_req step_req();
        return make_req(MODE_STEP, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom);
    endfunction

    // Coordinate near an edge of the frame, inside it, or anywhere
    function automatic int near_edge(int lim);
        case ($urandom_range(0, 3))
            0: return int'($urandom_range(0, 12)) - 6;
            1: return lim + int'($urandom_range(0, 12)) - 6;
            2: return $urandom_range(0, lim);
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // Drive one request at a falling edge, hold until accepted, then idle for a random gap, possibly none
    task automatic send(t_draw_req r);
        int gap;
        i_mode = r.mode;
        i_start_x = r.sx;
        i_start_y = r.sy;
        i_end_x = r.ex;
        i_end_y = r.ey;
        i_point_size = r.psize;
        i_draw_color = r.color;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(r);
        sent++;
        @(negedge i_clk);
        gap = idle_len();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic walk(t_draw_req r, int n);
        send(r);
        repeat (n) send(step_req());
    endtask

    // One random primitive: mostly complete walks, some cut short or over-stepped
    task automatic random_primitive(int lim_w, int lim_h);
        t_draw_req r;
        int        span, ddx, ddy, r100;
        longint    px, n;
        r = make_req(t_mode'($urandom_range(1, 3)), near_edge(lim_w), near_edge(lim_h),
                     0, 0, $urandom, $urandom);
        span = ($urandom_range(0, 9) == 0) ? 40 : 6;
        if ($urandom_range(0, 9) == 0) begin
            r.ex = 16'($urandom);
            r.ey = 16'($urandom);
        end else begin
            r.ex = 16'(int'(r.sx) + int'($urandom_range(0, 2 * span)) - span);
            r.ey = 16'(int'(r.sy) + int'($urandom_range(0, 2 * span)) - span);
        end
        r100 = $urandom_range(0, 99);
        if (r100 < 80) r.psize = $urandom_range(0, 7);
        else if (r100 < 95) r.psize = $urandom_range(8, 20);

        ddx = int'(r.ex) - int'(r.sx);
        ddy = int'(r.ey) - int'(r.sy);
        if (ddx < 0) ddx = -ddx;
        if (ddy < 0) ddy = -ddy;
        case (r.mode)
            MODE_LINE: px = ((ddx > ddy) ? ddx : ddy) + 1;
            MODE_RECT: px = longint'(ddx + 1) * longint'(ddy + 1);
            default:   px = longint'(r.psize) * longint'(r.psize);
        endcase
        n = px;
        if (px > 200) n = $urandom_range(1, 20);
        r100 = $urandom_range(0, 99);
        if (r100 < 15) n = $urandom_range(0, int'(n));
        else if (r100 < 25) n = n + $urandom_range(1, 3);
        walk(r, int'(n));
    endtask

    // Frame register write, only with all expected pixels drained
    task automatic write_frame(t_cfg_idx idx, logic [CFG_W-1:0] v);
        i_in_valid = 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = v;
        sb.set_frame(idx, v);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Pixel consumer: random stalls
    initial begin : consumer
        int stall;
        stall = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready = 1'b0;
                stall--;
            end else begin
                i_out_ready = 1'b1;
                if ($urandom_range(0, 4) == 0) stall = idle_len();
            end
        end
    end

    // Pixel monitor
    always @(posedge i_clk) begin : monitor
        t_pixel got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.x = o_pixel_x;
            got.y = o_pixel_y;
            got.addr = o_pixel_address;
            got.color = o_pixel_color;
            got.we = o_write_enable;
            got.last = o_last_pixel;
            sb.check_pixel(got);
        end
    end

    // Watchdog
    initial begin
        repeat (RUN_LIMIT) @(posedge i_clk);
        $display("raster_primitive_walker regression: fail");
        $finish;
    end

    initial begin : stimulus
        int phase_w[NUM_PHASES];
        int phase_h[NUM_PHASES];
        int lim_w, lim_h, quota;
        phase_w = '{640, 1, 4096, 8191, 0, 0, 17};
        phase_h = '{480, 1, 4096, 6000, 0, 0, 9};
        sb = new();
        steady = 0;
        sent = 0;
        settings_used = 1;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_FRAME_WIDTH;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_mode = MODE_STEP;
        i_start_x = '0;
        i_start_y = '0;
        i_end_x = '0;
        i_end_y = '0;
        i_point_size = '0;
        i_draw_color = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: idle step, both line directions, swapped corners, point sizes,
        // abandoned walks at the coordinate extremes, single-pixel line
        send(step_req());
        walk(make_req(MODE_LINE, 0, 0, 2, 1, 0, 32'hFFFF_FFFF), 3);
        walk(make_req(MODE_LINE, 5, 5, 3, 7, 255, 32'h0000_0000), 3);
        walk(make_req(MODE_RECT, 1, 0, 0, 1, 0, 32'hA5A5_A5A5), 4);
        walk(make_req(MODE_POINT, 100, 100, 0, 0, 0, 32'h1234_5678), 1);
        walk(make_req(MODE_POINT, 0, 0, 0, 0, 2, 32'h5A5A_5A5A), 4);
        walk(make_req(MODE_LINE, -32768, -32768, 32767, 32767, 0, 32'h8000_0001), 1);
        walk(make_req(MODE_POINT, 32767, -32768, 0, 0, 255, 32'h7FFF_FFFE), 1);
        walk(make_req(MODE_RECT, -32768, 32767, 32767, -32768, 0, 32'h0F0F_F0F0), 1);
        walk(make_req(MODE_LINE, 639, 479, 639, 479, 0, 32'hDEAD_BEEF), 1);

        // Random phases, each with its own frame size
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 5) begin
                phase_w[p] = $urandom_range(1, 4096);
                phase_h[p] = $urandom_range(1, 4096);
            end
            if (p > 0) begin
                write_frame(CFG_FRAME_WIDTH, phase_w[p][CFG_W-1:0]);
                write_frame(CFG_FRAME_HEIGHT, phase_h[p][CFG_W-1:0]);
                settings_used++;
            end
            steady = (p == 2);
            lim_w = (phase_w[p] > FRAME_CAP) ? FRAME_CAP : phase_w[p];
            lim_h = (phase_h[p] > FRAME_CAP) ? FRAME_CAP : phase_h[p];
            quota = sent + (ITEM_GOAL - sent) / (NUM_PHASES - p);
            while (sent < quota) begin
                if ($urandom_range(0, 99) < 20)
                    send(make_req(t_mode'($urandom_range(0, 3)), $urandom, $urandom,
                                  $urandom, $urandom, $urandom, $urandom));
                else
                    random_primitive(lim_w, lim_h);
            end
        end
        steady = 0;

        // Drain and settle
        i_in_valid = 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("Ran %0d requests over %0d frame sizes; %0d pixels checked, %0d clipped.",
                 sent, settings_used, sb.checked, sb.clipped);
        if (sb.mismatches == 0) begin
            $display("raster_primitive_walker regression: pass");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("raster_primitive_walker regression: fail");
        end
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/rpw_pkg.sv
rtl/rpw_clip_addr.sv
rtl/raster_primitive_walker.sv
sim/tb_top.sv
